### hdl/crcfr_pkg.sv
// crcfr_pkg: types, codes and the crc-8 step shared by the frame receiver
// no dependencies; compile first

package crcfr_pkg;

    // start of frame marker
    localparam logic [7:0] START_BYTE = 8'h24;
    // reflected crc-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h91;
    // bytes in one value of the body
    localparam int VALUE_BYTES = 4;
    localparam int VALUE_SHIFT = $clog2(VALUE_BYTES);

    // receiver phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_CHECK = 2'd2,
        PH_BODY  = 2'd3
    } phase_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_BUSY   = 3'd0,
        ST_OK     = 3'd1,
        ST_BADCRC = 3'd2,
        ST_NOMSG  = 3'd3,
        ST_BADLEN = 3'd4
    } status_t;

    // one received byte
    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    // one result item
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] byte_pos;
        logic       last;
        logic [2:0] status;
        logic [5:0] value_count;
    } result_item_t;

    // input register towards the frame parser
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } staged_byte_t;

    // crc-8 over one byte, lsb first, unrolled over the eight bits
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = c ^ CRC_POLY;
            end
            c = {1'b0, c[7:1]};
        end
        return c;
    endfunction

endpackage

### hdl/crcfr_rx_if.sv
// crcfr_rx_if: valid/ready channel carrying received bytes
// depends on crcfr_pkg

interface crcfr_rx_if;
    logic                valid;
    logic                ready;
    crcfr_pkg::rx_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/crcfr_res_if.sv
// crcfr_res_if: valid/ready channel carrying result items
// depends on crcfr_pkg

interface crcfr_res_if;
    logic                    valid;
    logic                    ready;
    crcfr_pkg::result_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/crcfr_in_stage.sv
// crcfr_in_stage: input register in front of the frame parser
// depends on crcfr_pkg and crcfr_rx_if

module crcfr_in_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    crcfr_rx_if.sink                rx,
    input  logic                    take,
    output crcfr_pkg::staged_byte_t staged
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // room when empty or when the held byte moves on this cycle
    assign rx.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (rx.valid && rx.ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // byte capture on each transfer
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.data.rx_byte;
        end
    end

    assign staged.valid   = valid_reg;
    assign staged.rx_byte = byte_reg;

endmodule

### hdl/crcfr_parser.sv
// crcfr_parser: frame state machine, running crc-8 and result register
// depends on crcfr_pkg and crcfr_res_if

module crcfr_parser (
    input  logic                    clk,
    input  logic                    rst_n,
    input  crcfr_pkg::staged_byte_t staged,
    output logic                    take,
    crcfr_res_if.source             res
);

    crcfr_pkg::phase_t       phase_reg;
    crcfr_pkg::phase_t       phase_next;
    logic [7:0]              frame_length_reg;
    logic [7:0]              frame_length_next;
    logic [7:0]              body_remaining_reg;
    logic [7:0]              body_remaining_next;
    logic [7:0]              expected_check_reg;
    logic [7:0]              expected_check_next;
    logic [7:0]              running_check_reg;
    logic [7:0]              running_check_next;
    logic [7:0]              body_index_reg;
    logic [7:0]              body_index_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    crcfr_pkg::result_item_t out_item_reg;
    crcfr_pkg::result_item_t item;
    logic                    has_result;
    logic [7:0]              b;
    logic [7:0]              crc_new;
    logic [7:0]              remaining_dec;
    logic [7:0]              len_minus2;
    logic [5:0]              count;

    assign b             = staged.rx_byte;
    assign crc_new       = crcfr_pkg::crc8_update(running_check_reg, b);
    assign remaining_dec = body_remaining_reg - 8'd1;
    assign len_minus2    = frame_length_reg - 8'd2;
    assign count         = (frame_length_reg < 8'd2) ? 6'd0
                         : len_minus2[7:crcfr_pkg::VALUE_SHIFT];

    // a byte moves on when the result register is free or being emptied
    assign take = staged.valid && (!out_valid_reg || res.ready);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            unique case (phase_reg)
                crcfr_pkg::PH_IDLE:
                begin
                    if (b == crcfr_pkg::START_BYTE)
                    begin
                        phase_next = crcfr_pkg::PH_LEN;
                    end
                end
                crcfr_pkg::PH_LEN:
                begin
                    phase_next = (b == 8'd0) ? crcfr_pkg::PH_IDLE : crcfr_pkg::PH_CHECK;
                end
                crcfr_pkg::PH_CHECK:
                begin
                    phase_next = (frame_length_reg == 8'd1) ? crcfr_pkg::PH_IDLE
                                                            : crcfr_pkg::PH_BODY;
                end
                crcfr_pkg::PH_BODY:
                begin
                    if (remaining_dec == 8'd0)
                    begin
                        phase_next = crcfr_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = crcfr_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // frame registers and the result for the byte in hand
    always_comb
    begin
        frame_length_next   = frame_length_reg;
        body_remaining_next = body_remaining_reg;
        expected_check_next = expected_check_reg;
        running_check_next  = running_check_reg;
        body_index_next     = body_index_reg;
        has_result          = 1'b0;
        item                = '0;
        unique case (phase_reg)
            crcfr_pkg::PH_IDLE:
            begin
                if (b != crcfr_pkg::START_BYTE)
                begin
                    has_result  = 1'b1;
                    item.last   = 1'b1;
                    item.status = crcfr_pkg::ST_NOMSG;
                end
            end
            crcfr_pkg::PH_LEN:
            begin
                if (b == 8'd0)
                begin
                    has_result  = 1'b1;
                    item.last   = 1'b1;
                    item.status = crcfr_pkg::ST_BADLEN;
                end
                else
                begin
                    frame_length_next = b;
                end
            end
            crcfr_pkg::PH_CHECK:
            begin
                expected_check_next = b;
                running_check_next  = 8'd0;
                body_index_next     = 8'd0;
                if (frame_length_reg == 8'd1)
                begin
                    // empty body: crc is zero
                    body_remaining_next = 8'd0;
                    has_result          = 1'b1;
                    item.last           = 1'b1;
                    item.status         = (b == 8'd0) ? crcfr_pkg::ST_OK
                                                      : crcfr_pkg::ST_BADCRC;
                end
                else
                begin
                    body_remaining_next = frame_length_reg - 8'd1;
                end
            end
            crcfr_pkg::PH_BODY:
            begin
                running_check_next  = crc_new;
                body_index_next     = body_index_reg + 8'd1;
                body_remaining_next = remaining_dec;
                has_result          = 1'b1;
                item.data_byte      = b;
                item.byte_pos       = body_index_reg;
                if (remaining_dec == 8'd0)
                begin
                    item.last        = 1'b1;
                    item.status      = (crc_new == expected_check_reg) ? crcfr_pkg::ST_OK
                                                                       : crcfr_pkg::ST_BADCRC;
                    item.value_count = count;
                end
                else
                begin
                    item.status = crcfr_pkg::ST_BUSY;
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = has_result;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= crcfr_pkg::PH_IDLE;
            frame_length_reg   <= 8'd0;
            body_remaining_reg <= 8'd0;
            expected_check_reg <= 8'd0;
            running_check_reg  <= 8'd0;
            body_index_reg     <= 8'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                frame_length_reg   <= frame_length_next;
                body_remaining_reg <= body_remaining_next;
                expected_check_reg <= expected_check_next;
                running_check_reg  <= running_check_next;
                body_index_reg     <= body_index_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take && has_result)
        begin
            out_item_reg <= item;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_item_reg;

endmodule

### hdl/crc_checked_frame_receiver.sv
// crc_checked_frame_receiver: length-prefixed frame receiver with crc-8 check
// depends on crcfr_pkg, crcfr_rx_if, crcfr_res_if, crcfr_in_stage, crcfr_parser
//
// usage
//   rx carries one received byte per transfer (valid/ready). a frame is '$',
//   a length byte, a check byte, then length-1 body bytes. res carries one
//   result per body byte (byte, position, status in progress); the result
//   of the last body byte has last set, status ok or bad crc and the value count.
//   a byte other than '$' while idle gives a no-message result; a length of
//   zero gives a bad-length result; start, length and check bytes of a longer
//   frame give no result. a one-byte frame ends on its check byte.
// timing
//   a byte taken from rx is held in the input register; its result is then
//   written into the result register, and a stall of res holds it back. one
//   byte per cycle is sustained while the sink keeps ready high, as the
//   unrolled crc-8 update between the two registers is combinational.
// reset and stall
//   rst_n clears the phase to idle and empties both registers. while the
//   sink holds ready low the result is held stable; a byte can still be taken
//   into an empty input register, after which rx.ready drops until space frees.

module crc_checked_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    crcfr_rx_if.sink    rx,
    crcfr_res_if.source res
);

    crcfr_pkg::staged_byte_t staged;
    logic                    take;

    // input register
    crcfr_in_stage u_in_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .take   (take),
        .staged (staged)
    );

    // frame parser and result register
    crcfr_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .staged (staged),
        .take   (take),
        .res    (res)
    );

endmodule
